// ===== rtl/ads_pkg.sv =====
package ads_pkg;

	localparam int PIX_W       = 16;
	localparam int DVD_W       = 32;
	localparam int DEN_W       = 16;
	localparam int SUM_W       = 18;
	localparam int MUL_A_W     = 18;
	localparam int MUL_B_W     = 19;
	localparam int PROD_W      = MUL_A_W + MUL_B_W;
	// floor(x / 3) == (x * 349526) >> 20 for every x below 2**19
	localparam logic [MUL_B_W-1:0] THIRD_MUL = 19'd349526;
	localparam int THIRD_SHIFT = 20;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;

	typedef enum logic [2:0] {
		REG_LUM_MIN    = 3'd0,
		REG_LUM_MAX    = 3'd1,
		REG_SHIFT      = 3'd2,
		REG_FULL_SCALE = 3'd3,
		REG_SCAN_NORTH = 3'd4,
		REG_MARK_MODE  = 3'd5,
		REG_TEST_MASK  = 3'd6,
		REG_LEFT_MASK  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] lum_min;
		logic [PIX_W-1:0] lum_max;
		logic [6:0]       shift_amount;
		logic [PIX_W-1:0] pixel_full_scale;
		logic             scan_north;
		logic             mark_mode;
		logic [PIX_W-1:0] overlay_test_mask;
		logic [PIX_W-1:0] overlay_left_mask;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

endpackage

// ===== rtl/ads_ram.sv =====
module ads_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ads_div.sv =====
module ads_div import ads_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             qbit;
	logic [DEN_W-1:0] rem_next;

	// restoring division, one quotient bit per cycle
	always_comb begin
		trial    = {rem_q, quo_q[DVD_W-1]};
		diff     = trial - {1'b0, den_q};
		qbit     = (trial >= {1'b0, den_q});
		rem_next = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DVD_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/ads_regs.sv =====
module ads_regs import ads_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lum_min           <= '0;
			cfg_q.lum_max           <= 16'hffff;
			cfg_q.shift_amount      <= '0;
			cfg_q.pixel_full_scale  <= 16'd255;
			cfg_q.scan_north        <= 1'b0;
			cfg_q.mark_mode         <= 1'b0;
			cfg_q.overlay_test_mask <= '0;
			cfg_q.overlay_left_mask <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_LUM_MIN:    cfg_q.lum_min           <= pwdata[PIX_W-1:0];
				REG_LUM_MAX:    cfg_q.lum_max           <= pwdata[PIX_W-1:0];
				REG_SHIFT:      cfg_q.shift_amount      <= pwdata[6:0];
				REG_FULL_SCALE: cfg_q.pixel_full_scale  <= pwdata[PIX_W-1:0];
				REG_SCAN_NORTH: cfg_q.scan_north        <= pwdata[0];
				REG_MARK_MODE:  cfg_q.mark_mode         <= pwdata[0];
				REG_TEST_MASK:  cfg_q.overlay_test_mask <= pwdata[PIX_W-1:0];
				REG_LEFT_MASK:  cfg_q.overlay_left_mask <= pwdata[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_LUM_MIN:    prdata = DATA_W'(cfg_q.lum_min);
			REG_LUM_MAX:    prdata = DATA_W'(cfg_q.lum_max);
			REG_SHIFT:      prdata = DATA_W'(cfg_q.shift_amount);
			REG_FULL_SCALE: prdata = DATA_W'(cfg_q.pixel_full_scale);
			REG_SCAN_NORTH: prdata = DATA_W'(cfg_q.scan_north);
			REG_MARK_MODE:  prdata = DATA_W'(cfg_q.mark_mode);
			REG_TEST_MASK:  prdata = DATA_W'(cfg_q.overlay_test_mask);
			REG_LEFT_MASK:  prdata = DATA_W'(cfg_q.overlay_left_mask);
			default:        prdata = '0;
		endcase
	end

endmodule

// ===== rtl/anaglyph_depth_shift_core.sv =====
// red/cyan anaglyph depth shifter, one pixel per request on the s_ stream,
// one result per request on the m_ stream, registers on the apb port.
// a request carries r/g/b/overlay and an optional luminance; s_tuser[1]
// marks the first pixel of a line and clears the pixel history.
// a pixel is processed by a small sequencer around one shared multiplier
// and one serial divider; s_tready is high only while the sequencer idles.
// paths from accept to m_tvalid:
//   pass-through (shift 0): straight to the output state
//   mark mode: through the luminance and clipping states, then out
//   shifting: two runs of the serial divider, then the history write and reads
//   (full scale zero skips the second run)
// the history is a ram of HISTORY_DEPTH entries with a read port shared
// between the left and right position, plus one valid flop per entry.
// the result sits in an output register; the next pixel is accepted while
// it waits, and the sequencer only holds its next result while m_tready
// stays low. after reset all history reads as zero and no clearing pass runs.
// the user must write configuration only while the block is idle; it is not enforced.
module anaglyph_depth_shift_core import ads_pkg::*; #(
	parameter int HISTORY_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// red, green, blue, overlay, external_lum
	input  logic [79:0]       s_tdata,
	// use_external_lum, line_start
	input  logic [1:0]        s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// red, green, blue, overlay
	output logic [63:0]       m_tdata,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int AW  = $clog2(HISTORY_DEPTH);
	localparam int SW  = $clog2(HISTORY_DEPTH + 1);
	localparam int SW1 = SW + 1;
	localparam int CW  = (SW > 7) ? SW : 7;
	localparam int EW  = 4 * PIX_W;

	typedef enum logic [14:0] {
		ST_IDLE   = 15'h0001,
		ST_MUL3   = 15'h0002,
		ST_LUMSET = 15'h0004,
		ST_CLIP   = 15'h0008,
		ST_MUL1   = 15'h0010,
		ST_DIV1   = 15'h0020,
		ST_WAIT1  = 15'h0040,
		ST_MUL2   = 15'h0080,
		ST_DIV2   = 15'h0100,
		ST_WAIT2  = 15'h0200,
		ST_WR     = 15'h0400,
		ST_RDL    = 15'h0800,
		ST_RDR    = 15'h1000,
		ST_RDD    = 15'h2000,
		ST_OUT    = 15'h4000
	} state_t;

	cfg_t cfg;

	state_t              state_q;
	logic [AW-1:0]       phase_q;
	logic [HISTORY_DEPTH-1:0] valid_q;
	logic                m_tvalid_q;
	logic [EW-1:0]       m_tdata_q;

	logic [PIX_W-1:0]    r_q, g_q, b_q, ov_q, ext_q;
	logic                use_ext_q;
	logic [SUM_W-1:0]    sum_q;
	logic [AW-1:0]       p_q;
	logic [PIX_W-1:0]    lum_q, lum_c_q, dif_q, q_q;
	logic [SW-1:0]       dx_q;
	logic [PROD_W-1:0]   prod_q;
	logic [AW-1:0]       pl_q, pr_q;
	logic                vl_q, vr_q;
	logic [EW-1:0]       el_q;
	logic [EW-1:0]       res_q;

	logic                in_acc;
	logic                ls;
	logic [CW-1:0]       sa_ext;
	logic [SW-1:0]       s_w;
	logic [AW-1:0]       cur_ph, p_sel, ph_next;
	logic [SW-1:0]       p1;
	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic [PROD_W-1:0]   mul_p;
	logic [PIX_W:0]      hi;
	logic [PIX_W-1:0]    lum_clip;
	logic [PIX_W-1:0]    mk_r, mk_g, mk_b;
	logic [SW1-1:0]      pe, sh_pos;
	logic [AW-1:0]       shifted;
	logic [PIX_W-1:0]    ov_store;
	logic [EW-1:0]       entry;
	logic                ram_we;
	logic [AW-1:0]       ram_raddr;
	logic [EW-1:0]       ram_rdata;
	logic [EW-1:0]       el, er;
	logic [PIX_W-1:0]    ov_merge;
	div_req_t            div_req;
	logic                div_done;
	logic [DVD_W-1:0]    div_quo;
	logic                out_free;

	ads_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ads_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	ads_ram #(
		.WIDTH (EW),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (p_q),
		.wdata (entry),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign ls       = s_tuser[1];
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	// effective shift, saturated at the history depth
	always_comb begin
		sa_ext = CW'(cfg.shift_amount);
		s_w    = (sa_ext >= CW'(HISTORY_DEPTH)) ? SW'(HISTORY_DEPTH) : SW'(sa_ext);
	end

	// phase of the incoming pixel, restarted when out of range
	always_comb begin
		cur_ph  = ls ? '0 : phase_q;
		p_sel   = (SW'(cur_ph) < s_w) ? cur_ph : '0;
		p1      = SW'(p_sel) + SW'(1);
		ph_next = (p1 == s_w) ? '0 : AW'(p1);
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL3: begin
				mul_a = sum_q;
				mul_b = THIRD_MUL;
			end
			ST_MUL1: begin
				mul_a = MUL_A_W'(lum_c_q - cfg.lum_min);
				mul_b = MUL_B_W'(cfg.pixel_full_scale);
			end
			ST_MUL2: begin
				mul_a = MUL_A_W'(cfg.pixel_full_scale - q_q);
				mul_b = MUL_B_W'(s_w);
			end
			default: ;
		endcase
	end
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// clipping window and mark-mode blanking
	always_comb begin
		hi = (cfg.lum_max <= cfg.lum_min) ? ({1'b0, cfg.lum_min} + 1'b1)
			: {1'b0, cfg.lum_max};
		if ({1'b0, lum_q} > hi) begin
			lum_clip = hi[PIX_W-1:0];
		end else if (lum_q < cfg.lum_min) begin
			lum_clip = cfg.lum_min;
		end else begin
			lum_clip = lum_q;
		end
		mk_r = r_q;
		mk_g = g_q;
		mk_b = b_q;
		if (lum_q < cfg.lum_min) begin
			mk_g = '0;
			mk_b = '0;
		end
		if (lum_q > cfg.lum_max) begin
			mk_r = '0;
			mk_b = '0;
		end
	end

	// shifted position (p - dx) mod s
	always_comb begin
		pe = SW1'(p_q);
		if (pe >= SW1'(dx_q)) begin
			sh_pos = pe - SW1'(dx_q);
		end else begin
			sh_pos = pe + SW1'(s_w) - SW1'(dx_q);
		end
		shifted = AW'(sh_pos);
	end

	always_comb begin
		ov_store = ((ov_q & cfg.overlay_test_mask) != '0)
			? (ov_q | cfg.overlay_left_mask) : ov_q;
		entry    = {ov_store, b_q, g_q, r_q};
		ram_we   = (state_q == ST_WR);
		ram_raddr = (state_q == ST_RDR) ? pr_q : pl_q;
		el       = vl_q ? el_q : '0;
		er       = vr_q ? ram_rdata : '0;
		ov_merge = (el[4*PIX_W-1:3*PIX_W] & cfg.overlay_left_mask)
			| (er[4*PIX_W-1:3*PIX_W] & ~cfg.overlay_left_mask);
	end

	always_comb begin
		div_req.start    = (state_q == ST_DIV1) || (state_q == ST_DIV2);
		div_req.dividend = prod_q[DVD_W-1:0];
		div_req.divisor  = (state_q == ST_DIV1) ? dif_q : cfg.pixel_full_scale;
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= '0;
			valid_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (ls) begin
							valid_q <= '0;
						end
						if (s_w == '0) begin
							phase_q <= cur_ph;
							state_q <= ST_OUT;
						end else begin
							phase_q <= ph_next;
							state_q <= ST_MUL3;
						end
					end
				end
				ST_MUL3:   state_q <= ST_LUMSET;
				ST_LUMSET: state_q <= ST_CLIP;
				ST_CLIP:   state_q <= cfg.mark_mode ? ST_OUT : ST_MUL1;
				ST_MUL1:   state_q <= ST_DIV1;
				ST_DIV1:   state_q <= ST_WAIT1;
				ST_WAIT1: begin
					if (div_done) begin
						state_q <= (cfg.pixel_full_scale == '0) ? ST_WR : ST_MUL2;
					end
				end
				ST_MUL2:   state_q <= ST_DIV2;
				ST_DIV2:   state_q <= ST_WAIT2;
				ST_WAIT2: begin
					if (div_done) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					valid_q[p_q] <= 1'b1;
					state_q      <= ST_RDL;
				end
				ST_RDL:    state_q <= ST_RDR;
				ST_RDR:    state_q <= ST_RDD;
				ST_RDD:    state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					r_q       <= s_tdata[15:0];
					g_q       <= s_tdata[31:16];
					b_q       <= s_tdata[47:32];
					ov_q      <= s_tdata[63:48];
					ext_q     <= s_tdata[79:64];
					use_ext_q <= s_tuser[0];
					sum_q     <= SUM_W'(s_tdata[15:0]) + SUM_W'(s_tdata[31:16])
						+ SUM_W'(s_tdata[47:32]);
					p_q       <= p_sel;
					res_q     <= s_tdata[63:0];
				end
			end
			ST_MUL3, ST_MUL1, ST_MUL2: begin
				prod_q <= mul_p;
			end
			ST_LUMSET: begin
				lum_q <= use_ext_q ? ext_q : prod_q[THIRD_SHIFT +: PIX_W];
			end
			ST_CLIP: begin
				lum_c_q <= lum_clip;
				dif_q   <= PIX_W'(hi - {1'b0, cfg.lum_min});
				res_q   <= {ov_q, mk_b, mk_g, mk_r};
			end
			ST_WAIT1: begin
				q_q  <= div_quo[PIX_W-1:0];
				dx_q <= s_w - SW'(1);
			end
			ST_WAIT2: begin
				if (div_quo >= DVD_W'(s_w)) begin
					dx_q <= s_w - SW'(1);
				end else begin
					dx_q <= SW'(div_quo);
				end
			end
			ST_WR: begin
				pl_q <= cfg.scan_north ? p_q : shifted;
				pr_q <= cfg.scan_north ? shifted : p_q;
			end
			ST_RDL: begin
				vl_q <= valid_q[pl_q];
			end
			ST_RDR: begin
				el_q <= ram_rdata;
				vr_q <= valid_q[pr_q];
			end
			ST_RDD: begin
				res_q <= {ov_merge, er[3*PIX_W-1:2*PIX_W], er[2*PIX_W-1:PIX_W],
					el[PIX_W-1:0]};
			end
			ST_OUT: begin
				if (out_free) begin
					m_tdata_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_WAIT1 || state_q == ST_WAIT2))
		else $error("divider finished while the sequencer was not waiting");

	a_dx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> (dx_q < s_w && SW'(p_q) < s_w))
		else $error("depth shift or phase outside the history window");

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && m_tvalid_q && !m_tready) |=> m_tvalid_q && state_q == ST_OUT)
		else $error("result register overwritten while stalled");

endmodule
